>>> rtl/bpc_pkg.sv
// Shared types and constants for the button press classifier.
package bpc_pkg;

   localparam int unsigned CFG_ADDR_W = 5;
   localparam int unsigned CFG_DATA_W = 32;
   localparam int unsigned CFG_REG_W  = 16;
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned CODE_W     = 3;
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 72;

   localparam logic [2:0] REG_DEBOUNCE     = 3'd0;
   localparam logic [2:0] REG_SETTLE       = 3'd1;
   localparam logic [2:0] REG_LONG         = 3'd2;
   localparam logic [2:0] REG_SHORT_MAX    = 3'd3;
   localparam logic [2:0] REG_REBOOT_DELAY = 3'd4;
   localparam logic [2:0] REG_MAX_GAP      = 3'd5;

   localparam logic [CFG_REG_W-1:0] DEBOUNCE_RST     = 16'd50;
   localparam logic [CFG_REG_W-1:0] SETTLE_RST       = 16'd100;
   localparam logic [CFG_REG_W-1:0] LONG_RST         = 16'd8000;
   localparam logic [CFG_REG_W-1:0] SHORT_MAX_RST    = 16'd2000;
   localparam logic [CFG_REG_W-1:0] REBOOT_DELAY_RST = 16'd500;
   localparam logic [CFG_REG_W-1:0] MAX_GAP_RST      = 16'd100;

   typedef enum logic [CODE_W-1:0] {
      EV_NONE    = 3'd0,
      EV_ARMED   = 3'd1,
      EV_CANCEL  = 3'd2,
      EV_UNSURE  = 3'd3,
      EV_DROPPED = 3'd4,
      EV_BOOTREL = 3'd5,
      EV_REBOOT  = 3'd6,
      EV_UNPAIR  = 3'd7
   } event_type;

   typedef struct packed {
      logic [6:0]        pad;
      logic [TIME_W-1:0] now_ms;
      logic              pin_low;
   } req_data_type;

   typedef struct packed {
      logic [1:0]        pad;
      logic [TIME_W-1:0] press_gap_ms;
      logic [TIME_W-1:0] press_duration_ms;
      logic [CODE_W-1:0] phase_now;
      logic [CODE_W-1:0] event_code;
   } rsp_data_type;

endpackage

>>> rtl/button_press_classifier.sv
// Button press classifier: debounce, press timing and event decision per pin poll.
//
// Usage: each request on req_* is one poll of the button pin (pin_low, now_ms).
// Every request yields exactly one response on rsp_* carrying the event code,
// the phase after the poll, and the duration and largest poll gap of the last
// completed press. The first poll after reset only initializes the block
// (Locked if the pin is held, Idle otherwise) and reports no event.
// rsp_tvalid is set in the cycle after a request is accepted. Throughput is
// one request per cycle unless the receiver stalls: the whole update is one
// pass of subtract/compare logic between the state registers and the response
// register. req_tready is high whenever the response register is empty or is
// being taken in the same cycle, so a stalled receiver holds the response and
// blocks new requests only while it stalls.
// Reset (synchronous, active high) clears all press state, empties the
// response register and restores the default thresholds; csr_pready is always
// high. Thresholds are written over the csr_* port (registers at byte
// addresses 0,4,..,20) by the user only while the block is idle (not enforced).
module button_press_classifier (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bpc_pkg::REQ_DATA_W-1:0]  req_tdata,   // pin_low, now_ms[31:0], zero pad
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bpc_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // event_code[2:0], phase_now[2:0],
                                                        // press_duration_ms, press_gap_ms, pad
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [bpc_pkg::CFG_ADDR_W-1:0]  csr_paddr,
   input  logic [bpc_pkg::CFG_DATA_W-1:0]  csr_pwdata,
   output logic [bpc_pkg::CFG_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   typedef enum logic [bpc_pkg::CODE_W-1:0] {
      PH_IDLE   = 3'd0,
      PH_HELD   = 3'd1,
      PH_ARMED  = 3'd2,
      PH_REBOOT = 3'd3,
      PH_UNPAIR = 3'd4,
      PH_LOCKED = 3'd5
   } phase_type;

   localparam int unsigned TW = bpc_pkg::TIME_W;
   localparam int unsigned RW = bpc_pkg::CFG_REG_W;

   // configuration
   logic [RW-1:0] debounce_ff, settle_ff, long_ff, short_max_ff, reboot_delay_ff, max_gap_ff;
   logic          csr_write;
   logic [2:0]    csr_index;

   // press state
   logic          started_ff, started_in;
   logic          raw_ff, raw_in;
   logic          stable_ff, stable_in;
   logic          high_valid_ff, high_valid_in;
   logic [TW-1:0] last_time_ff, last_time_in;
   logic [TW-1:0] raw_edge_ff, raw_edge_in;
   logic [TW-1:0] high_start_ff, high_start_in;
   logic [TW-1:0] press_start_ff, press_start_in;
   logic [TW-1:0] edge_gap_ff, edge_gap_in;
   logic [TW-1:0] run_gap_ff, run_gap_in;
   logic [TW-1:0] start_gap_ff, start_gap_in;
   logic [TW-1:0] hold_gap_ff, hold_gap_in;
   phase_type     phase_ff, phase_in;
   logic [TW-1:0] phase_time_ff, phase_time_in;
   logic [TW-1:0] last_press_ff, last_press_in;
   logic [TW-1:0] last_gap_ff, last_gap_in;

   // response register
   logic                   rsp_valid_ff;
   bpc_pkg::rsp_data_type  rsp_data_ff;
   bpc_pkg::event_type     event_in;

   bpc_pkg::req_data_type  req;
   logic                   accept;
   logic [TW-1:0]          now, gap, max_gap_w, arm_at;
   logic                   low, settled, debounced;

   assign req        = bpc_pkg::req_data_type'(req_tdata);
   assign now        = req.now_ms;
   assign low        = req.pin_low;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign max_gap_w  = {{(TW-RW){1'b0}}, max_gap_ff};
   assign arm_at     = {{(TW-RW){1'b0}}, (long_ff != '0) ? (long_ff - 1'b1) : long_ff};

   always_comb begin
      started_in     = started_ff;
      raw_in         = raw_ff;
      stable_in      = stable_ff;
      high_valid_in  = high_valid_ff;
      last_time_in   = last_time_ff;
      raw_edge_in    = raw_edge_ff;
      high_start_in  = high_start_ff;
      press_start_in = press_start_ff;
      edge_gap_in    = edge_gap_ff;
      run_gap_in     = run_gap_ff;
      start_gap_in   = start_gap_ff;
      hold_gap_in    = hold_gap_ff;
      phase_in       = phase_ff;
      phase_time_in  = phase_time_ff;
      last_press_in  = last_press_ff;
      last_gap_in    = last_gap_ff;
      event_in       = bpc_pkg::EV_NONE;
      gap            = now - last_time_ff;
      settled        = 1'b0;
      debounced      = 1'b0;

      if (!started_ff) begin
         started_in     = 1'b1;
         raw_in         = low;
         stable_in      = low;
         high_valid_in  = !low;
         last_time_in   = now;
         raw_edge_in    = now;
         high_start_in  = now;
         press_start_in = now;
         edge_gap_in    = '0;
         run_gap_in     = '0;
         start_gap_in   = '0;
         hold_gap_in    = '0;
         phase_in       = low ? PH_LOCKED : PH_IDLE;
         phase_time_in  = now;
      end else begin
         last_time_in = now;
         if (low != raw_ff) begin
            raw_in      = low;
            raw_edge_in = now;
            edge_gap_in = gap;
            run_gap_in  = '0;
         end else if (gap > run_gap_ff) begin
            run_gap_in = gap;
         end
         if (stable_ff && gap > hold_gap_ff) begin
            hold_gap_in = gap;
         end
         if (low) begin
            high_valid_in = 1'b0;
         end else if (!high_valid_ff || gap > max_gap_w) begin
            high_valid_in = 1'b1;
            high_start_in = now;
         end

         debounced = (raw_in != stable_ff) &&
                     ((now - raw_edge_in) >= {{(TW-RW){1'b0}}, debounce_ff});
         settled   = high_valid_in &&
                     ((now - high_start_in) >= {{(TW-RW){1'b0}}, settle_ff});

         if (debounced) begin
            stable_in = raw_in;
            if (raw_in) begin
               // press
               press_start_in = raw_edge_in;
               start_gap_in   = edge_gap_in;
               hold_gap_in    = run_gap_in;
               phase_in       = PH_HELD;
               phase_time_in  = now;
               if (phase_ff == PH_REBOOT || phase_ff == PH_UNPAIR) begin
                  event_in = bpc_pkg::EV_DROPPED;
               end
            end else begin
               // release
               last_press_in = raw_edge_in - press_start_ff;
               last_gap_in   = (start_gap_ff > hold_gap_in) ? start_gap_ff : hold_gap_in;
               phase_time_in = now;
               if (phase_ff == PH_LOCKED) begin
                  phase_in = PH_IDLE;
                  event_in = bpc_pkg::EV_BOOTREL;
               end else if (phase_ff == PH_ARMED) begin
                  phase_in = PH_UNPAIR;
               end else if (last_gap_in > max_gap_w) begin
                  phase_in = PH_IDLE;
                  event_in = bpc_pkg::EV_UNSURE;
               end else if (last_press_in < {{(TW-RW){1'b0}}, short_max_ff}) begin
                  phase_in = PH_REBOOT;
               end else begin
                  phase_in = PH_IDLE;
                  event_in = bpc_pkg::EV_CANCEL;
               end
            end
         end else begin
            case (phase_ff)
               PH_HELD: begin
                  if (raw_in && hold_gap_in <= max_gap_w &&
                      (now - press_start_ff) >= arm_at) begin
                     phase_in      = PH_ARMED;
                     phase_time_in = now;
                     event_in      = bpc_pkg::EV_ARMED;
                  end
               end
               PH_REBOOT: begin
                  if (settled &&
                      (now - phase_time_ff) >= {{(TW-RW){1'b0}}, reboot_delay_ff}) begin
                     phase_in      = PH_IDLE;
                     phase_time_in = now;
                     event_in      = bpc_pkg::EV_REBOOT;
                  end
               end
               PH_UNPAIR: begin
                  if (settled) begin
                     phase_in      = PH_IDLE;
                     phase_time_in = now;
                     event_in      = bpc_pkg::EV_UNPAIR;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff     <= 1'b0;
         raw_ff         <= 1'b0;
         stable_ff      <= 1'b0;
         high_valid_ff  <= 1'b0;
         last_time_ff   <= '0;
         raw_edge_ff    <= '0;
         high_start_ff  <= '0;
         press_start_ff <= '0;
         edge_gap_ff    <= '0;
         run_gap_ff     <= '0;
         start_gap_ff   <= '0;
         hold_gap_ff    <= '0;
         phase_ff       <= PH_IDLE;
         phase_time_ff  <= '0;
         last_press_ff  <= '0;
         last_gap_ff    <= '0;
      end else if (accept) begin
         started_ff     <= started_in;
         raw_ff         <= raw_in;
         stable_ff      <= stable_in;
         high_valid_ff  <= high_valid_in;
         last_time_ff   <= last_time_in;
         raw_edge_ff    <= raw_edge_in;
         high_start_ff  <= high_start_in;
         press_start_ff <= press_start_in;
         edge_gap_ff    <= edge_gap_in;
         run_gap_ff     <= run_gap_in;
         start_gap_ff   <= start_gap_in;
         hold_gap_ff    <= hold_gap_in;
         phase_ff       <= phase_in;
         phase_time_ff  <= phase_time_in;
         last_press_ff  <= last_press_in;
         last_gap_ff    <= last_gap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff.pad               <= '0;
         rsp_data_ff.event_code        <= event_in;
         rsp_data_ff.phase_now         <= phase_in;
         rsp_data_ff.press_duration_ms <= last_press_in;
         rsp_data_ff.press_gap_ms      <= last_gap_in;
      end
   end

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff     <= bpc_pkg::DEBOUNCE_RST;
         settle_ff       <= bpc_pkg::SETTLE_RST;
         long_ff         <= bpc_pkg::LONG_RST;
         short_max_ff    <= bpc_pkg::SHORT_MAX_RST;
         reboot_delay_ff <= bpc_pkg::REBOOT_DELAY_RST;
         max_gap_ff      <= bpc_pkg::MAX_GAP_RST;
      end else if (csr_write) begin
         case (csr_index)
            bpc_pkg::REG_DEBOUNCE:     debounce_ff     <= csr_pwdata[RW-1:0];
            bpc_pkg::REG_SETTLE:       settle_ff       <= csr_pwdata[RW-1:0];
            bpc_pkg::REG_LONG:         long_ff         <= csr_pwdata[RW-1:0];
            bpc_pkg::REG_SHORT_MAX:    short_max_ff    <= csr_pwdata[RW-1:0];
            bpc_pkg::REG_REBOOT_DELAY: reboot_delay_ff <= csr_pwdata[RW-1:0];
            bpc_pkg::REG_MAX_GAP:      max_gap_ff      <= csr_pwdata[RW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         bpc_pkg::REG_DEBOUNCE:     csr_prdata = {16'd0, debounce_ff};
         bpc_pkg::REG_SETTLE:       csr_prdata = {16'd0, settle_ff};
         bpc_pkg::REG_LONG:         csr_prdata = {16'd0, long_ff};
         bpc_pkg::REG_SHORT_MAX:    csr_prdata = {16'd0, short_max_ff};
         bpc_pkg::REG_REBOOT_DELAY: csr_prdata = {16'd0, reboot_delay_ff};
         bpc_pkg::REG_MAX_GAP:      csr_prdata = {16'd0, max_gap_ff};
         default:                   csr_prdata = '0;
      endcase
   end

   // checks
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tvalid)
      else $error("accepted request produced no response");

   a_idle_before_start: assert property (@(posedge clock) disable iff (reset)
      !started_ff |-> (phase_ff == PH_IDLE))
      else $error("phase left idle before first poll");

   a_armed_event_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_data_ff.event_code == bpc_pkg::EV_ARMED)
         |-> (rsp_data_ff.phase_now == PH_ARMED))
      else $error("armed event without armed phase");

   a_final_event_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_data_ff.event_code == bpc_pkg::EV_REBOOT ||
                      rsp_data_ff.event_code == bpc_pkg::EV_UNPAIR ||
                      rsp_data_ff.event_code == bpc_pkg::EV_CANCEL ||
                      rsp_data_ff.event_code == bpc_pkg::EV_UNSURE ||
                      rsp_data_ff.event_code == bpc_pkg::EV_BOOTREL))
         |-> (rsp_data_ff.phase_now == PH_IDLE))
      else $error("terminal event did not return to idle");

   a_first_poll_quiet: assert property (@(posedge clock) disable iff (reset)
      (accept && !started_ff) |=> (rsp_data_ff.event_code == bpc_pkg::EV_NONE))
      else $error("event reported on first poll");

endmodule
